/* rtl/core/vna_pkg.sv */
// Shared types and constants of the vertex normal accumulator.
`default_nettype none
package vna_pkg;

	// Fixed field widths
	localparam int unsigned POS_W = 16;
	localparam int unsigned IDX_FIELD_W = 16;
	localparam int unsigned NRM_W = 16;
	localparam int unsigned DIFF_W = POS_W + 1;
	localparam int unsigned PROD_W = 2 * DIFF_W;
	localparam int unsigned CROSS_W = PROD_W + 1;
	localparam int unsigned MAG_BITS = 31;
	localparam int unsigned SQ_W = 2 * MAG_BITS;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned LEN_W = 33;
	localparam int unsigned QUO_W = 17;
	localparam int unsigned NUM_W = MAG_BITS + 15 + 1;
	localparam int unsigned STEP_W = 6;

	// Sequencer step limits
	localparam logic [STEP_W-1:0] PRD_LAST = 6'd3;
	localparam logic [STEP_W-1:0] MUL_LAST = 6'd6;
	localparam logic [STEP_W-1:0] SQ_LAST = 6'd3;
	localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;
	localparam logic [STEP_W-1:0] DIV_LAST = 6'd16;
	localparam logic [1:0] COMP_LAST = 2'd2;

	localparam logic [SUM_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
	localparam logic [NRM_W-1:0] NRM_MAX = 16'd32767;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_TRI   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SKIP  = 3'd1,
		ST_FULL  = 3'd2,
		ST_ZERO  = 3'd3,
		ST_RDINV = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		OP_IDLE     = 5'd0,
		OP_LATCH    = 5'd1,
		OP_LOAD     = 5'd2,
		OP_CLEAR    = 5'd3,
		OP_POS_RD   = 5'd4,
		OP_DIFF     = 5'd5,
		OP_MUL      = 5'd6,
		OP_ACC_RD   = 5'd7,
		OP_ACC_WR   = 5'd8,
		OP_NRM_RD   = 5'd9,
		OP_NRM_CAP  = 5'd10,
		OP_NORM     = 5'd11,
		OP_SQ       = 5'd12,
		OP_SQRT     = 5'd13,
		OP_DIV_INIT = 5'd14,
		OP_DIV      = 5'd15,
		OP_DIV_END  = 5'd16,
		OP_FINISH   = 5'd17
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic [STEP_W-1:0]  step;
		logic [1:0]         comp;
		status_t            st;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t code;
		logic      full;
		logic      tri_bad;
		logic      rd_bad;
		logic      acc_zero;
		logic      norm_ok;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/vna_if.sv */
// Request and response channel interfaces of the vertex normal accumulator.
`default_nettype none
interface vna_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] read_index;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [15:0] index_a;
	logic [15:0] index_b;
	logic [15:0] index_c;

	modport source (
		output valid, command, read_index, pos_x, pos_y, pos_z,
		output index_a, index_b, index_c,
		input ready
	);
	modport sink (
		input valid, command, read_index, pos_x, pos_y, pos_z,
		input index_a, index_b, index_c,
		output ready
	);
endinterface

interface vna_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;

	modport source (output valid, status, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, status, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

/* rtl/core/vna_dp.sv */
// Datapath: vertex stores, cross product, saturating accumulate, normalize.
`default_nettype none
module vna_dp
	import vna_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = 1024,
	parameter int unsigned ACCUM_BITS = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	input  wire logic [1:0]            command,
	input  wire logic [IDX_FIELD_W-1:0] read_index,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic [IDX_FIELD_W-1:0] index_a,
	input  wire logic [IDX_FIELD_W-1:0] index_b,
	input  wire logic [IDX_FIELD_W-1:0] index_c,
	output logic [2:0]                 status,
	output logic signed [NRM_W-1:0]    normal_x,
	output logic signed [NRM_W-1:0]    normal_y,
	output logic signed [NRM_W-1:0]    normal_z
);

	localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int unsigned EXT_W = IDX_FIELD_W + 1;
	localparam int unsigned AB = ACCUM_BITS;
	localparam int unsigned ROW_W = 3 * POS_W;

	// Latched transaction
	cmd_code_t                 cmd_q;
	logic [IDX_FIELD_W-1:0]    vidx_q;
	logic [ROW_W-1:0]          pos_in_q;
	logic [IDX_FIELD_W-1:0]    corner_q [3];
	logic [CNT_W-1:0]          count_q;

	// Stores
	logic [ROW_W-1:0]          pos_mem [MAX_VERTICES];
	logic signed [AB-1:0]      accx_mem [MAX_VERTICES];
	logic signed [AB-1:0]      accy_mem [MAX_VERTICES];
	logic signed [AB-1:0]      accz_mem [MAX_VERTICES];
	logic [ROW_W-1:0]          pos_rd_q;
	logic signed [AB-1:0]      acc_rd_q [3];
	logic [IDX_W-1:0]          raddr;
	logic [IDX_FIELD_W-1:0]    corner_sel;

	// Triangle arithmetic
	logic [ROW_W-1:0]          tri_pos_q [3];
	logic signed [DIFF_W-1:0]  d1_q [3];
	logic signed [DIFF_W-1:0]  d2_q [3];
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CROSS_W-1:0] cross_q [3];
	logic signed [DIFF_W-1:0]  mul_a;
	logic signed [DIFF_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [AB-1:0]      acc_new [3];
	logic signed [AB:0]        acc_sum [3];

	// Normalization
	logic                      sign_q [3];
	logic [AB-1:0]             mag_q [3];
	logic [AB-1:0]             mag_or;
	logic [AB-1:0]             mag_sel;
	logic [SQ_W-1:0]           sq_q;
	logic [SQ_W-1:0]           sq_p;
	logic [SUM_W-1:0]          rad_q;
	logic [SUM_W-1:0]          res_q;
	logic [SUM_W-1:0]          bit_q;
	logic [SUM_W-1:0]          trial;
	logic [LEN_W-1:0]          len;
	logic [NUM_W-1:0]          num;
	logic [LEN_W-1:0]          rem_q;
	logic [QUO_W-1:0]          numlo_q;
	logic [QUO_W-1:0]          quo_q;
	logic [LEN_W:0]            div_t;
	logic                      div_ge;
	logic [NRM_W-1:0]          qmag;
	logic [NRM_W-1:0]          nrm_q [3];

	// Status toward the controller
	always_comb begin
		stat.code = cmd_q;
		stat.full = (count_q == CNT_W'(MAX_VERTICES));
		stat.tri_bad = (EXT_W'(corner_q[0]) >= EXT_W'(count_q)) ||
			(EXT_W'(corner_q[1]) >= EXT_W'(count_q)) ||
			(EXT_W'(corner_q[2]) >= EXT_W'(count_q));
		stat.rd_bad = (EXT_W'(vidx_q) >= EXT_W'(count_q));
		stat.acc_zero = (mag_or == '0);
		stat.norm_ok = (mag_or[AB-1:MAG_BITS] == '0) && mag_or[MAG_BITS-1];
	end

	assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

	// Select the corner, the read address and the magnitude
	always_comb begin
		unique case (cmd.comp)
			2'd0:    corner_sel = corner_q[0];
			2'd1:    corner_sel = corner_q[1];
			default: corner_sel = corner_q[2];
		endcase
		unique case (cmd.op)
			OP_POS_RD, OP_ACC_RD: raddr = corner_sel[IDX_W-1:0];
			OP_NRM_RD:            raddr = vidx_q[IDX_W-1:0];
			default:              raddr = '0;
		endcase
		unique case (cmd.comp)
			2'd0:    mag_sel = mag_q[0];
			2'd1:    mag_sel = mag_q[1];
			2'd2:    mag_sel = mag_q[2];
			default: mag_sel = '0;
		endcase
	end

	// Position store
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && !stat.full) begin
			pos_mem[count_q[IDX_W-1:0]] <= pos_in_q;
		end
		pos_rd_q <= pos_mem[raddr];
	end

	// Saturating accumulate of the cross product
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc_sum[k] = (AB+1)'(acc_rd_q[k]) + (AB+1)'(cross_q[k]);
			if (acc_sum[k][AB] != acc_sum[k][AB-1]) begin
				acc_new[k] = acc_sum[k][AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
			end else begin
				acc_new[k] = acc_sum[k][AB-1:0];
			end
		end
	end

	// Accumulator stores
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && !stat.full) begin
			accx_mem[count_q[IDX_W-1:0]] <= '0;
			accy_mem[count_q[IDX_W-1:0]] <= '0;
			accz_mem[count_q[IDX_W-1:0]] <= '0;
		end else if (cmd.op == OP_ACC_WR) begin
			accx_mem[corner_sel[IDX_W-1:0]] <= acc_new[0];
			accy_mem[corner_sel[IDX_W-1:0]] <= acc_new[1];
			accz_mem[corner_sel[IDX_W-1:0]] <= acc_new[2];
		end
		acc_rd_q[0] <= accx_mem[raddr];
		acc_rd_q[1] <= accy_mem[raddr];
		acc_rd_q[2] <= accz_mem[raddr];
	end

	// Vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_LOAD && !stat.full) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.op == OP_CLEAR) begin
			count_q <= '0;
		end
	end

	// Operand select for the shared 17x17 multiplier and the normalize arithmetic
	always_comb begin
		unique case (cmd.step)
			6'd0:    begin mul_a = d1_q[1]; mul_b = d2_q[2]; end
			6'd1:    begin mul_a = d1_q[2]; mul_b = d2_q[1]; end
			6'd2:    begin mul_a = d1_q[2]; mul_b = d2_q[0]; end
			6'd3:    begin mul_a = d1_q[0]; mul_b = d2_q[2]; end
			6'd4:    begin mul_a = d1_q[0]; mul_b = d2_q[1]; end
			default: begin mul_a = d1_q[1]; mul_b = d2_q[0]; end
		endcase
		mul_p = mul_a * mul_b;
		sq_p = mag_sel[MAG_BITS-1:0] * mag_sel[MAG_BITS-1:0];
		trial = res_q + bit_q;
		len = res_q[LEN_W-1:0];
		num = {mag_sel[MAG_BITS-1:0], 15'd0} + NUM_W'(len >> 1);
		div_t = {rem_q, numlo_q[QUO_W-1]};
		div_ge = (div_t >= (LEN_W+1)'(len));
		qmag = (quo_q > QUO_W'(NRM_MAX)) ? NRM_MAX : quo_q[NRM_W-1:0];
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				cmd_q <= cmd_code_t'(command);
				vidx_q <= read_index;
				pos_in_q <= {pos_x, pos_y, pos_z};
				corner_q[0] <= index_a;
				corner_q[1] <= index_b;
				corner_q[2] <= index_c;
			end
			OP_POS_RD: begin
				// shift in the corner read in the previous step
				if (cmd.step != '0) begin
					tri_pos_q[2] <= pos_rd_q;
					tri_pos_q[1] <= tri_pos_q[2];
					tri_pos_q[0] <= tri_pos_q[1];
				end
			end
			OP_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					d1_q[k] <= DIFF_W'($signed(tri_pos_q[1][ROW_W-1-POS_W*k -: POS_W])) -
						DIFF_W'($signed(tri_pos_q[0][ROW_W-1-POS_W*k -: POS_W]));
					d2_q[k] <= DIFF_W'($signed(tri_pos_q[2][ROW_W-1-POS_W*k -: POS_W])) -
						DIFF_W'($signed(tri_pos_q[0][ROW_W-1-POS_W*k -: POS_W]));
					cross_q[k] <= '0;
				end
			end
			OP_MUL: begin
				prod_q <= mul_p;
				// fold in the product of the previous step
				unique case (cmd.step)
					6'd1:    cross_q[0] <= cross_q[0] + CROSS_W'(prod_q);
					6'd2:    cross_q[0] <= cross_q[0] - CROSS_W'(prod_q);
					6'd3:    cross_q[1] <= cross_q[1] + CROSS_W'(prod_q);
					6'd4:    cross_q[1] <= cross_q[1] - CROSS_W'(prod_q);
					6'd5:    cross_q[2] <= cross_q[2] + CROSS_W'(prod_q);
					6'd6:    cross_q[2] <= cross_q[2] - CROSS_W'(prod_q);
					default: ;
				endcase
			end
			OP_NRM_CAP: begin
				for (int k = 0; k < 3; k++) begin
					sign_q[k] <= acc_rd_q[k][AB-1];
					mag_q[k] <= acc_rd_q[k][AB-1] ? ({AB{1'b0}} - acc_rd_q[k]) : acc_rd_q[k];
				end
			end
			OP_NORM: begin
				// one bit per cycle until the largest magnitude has 31 bits
				for (int k = 0; k < 3; k++) begin
					if (mag_or[AB-1:MAG_BITS] != '0) begin
						mag_q[k] <= mag_q[k] >> 1;
					end else begin
						mag_q[k] <= mag_q[k] << 1;
					end
				end
			end
			OP_SQ: begin
				sq_q <= sq_p;
				if (cmd.step == '0) begin
					rad_q <= '0;
					res_q <= '0;
					bit_q <= SQRT_BIT0;
				end else begin
					rad_q <= rad_q + SUM_W'(sq_q);
				end
			end
			OP_SQRT: begin
				if (rad_q >= trial) begin
					rad_q <= rad_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT: begin
				rem_q <= LEN_W'(num[NUM_W-1:QUO_W]);
				numlo_q <= num[QUO_W-1:0];
				quo_q <= '0;
			end
			OP_DIV: begin
				rem_q <= div_ge ? LEN_W'(div_t - (LEN_W+1)'(len)) : div_t[LEN_W-1:0];
				numlo_q <= numlo_q << 1;
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
			end
			OP_DIV_END: begin
				for (int k = 0; k < 3; k++) begin
					if (cmd.comp == 2'(k)) begin
						nrm_q[k] <= sign_q[k] ? (NRM_W'(0) - qmag) : qmag;
					end
				end
			end
			OP_FINISH: begin
				status <= cmd.st;
				if (cmd.st == ST_OK && cmd_q == CMD_READ) begin
					normal_x <= nrm_q[0];
					normal_y <= nrm_q[1];
					normal_z <= nrm_q[2];
				end else begin
					normal_x <= '0;
					normal_y <= '0;
					normal_z <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/vna_ctrl.sv */
// Controller: sequences each transaction through the datapath.
`default_nettype none
module vna_ctrl
	import vna_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DISP  = 16'h0002,
		S_PRD   = 16'h0004,
		S_DIFF  = 16'h0008,
		S_MUL   = 16'h0010,
		S_ARD   = 16'h0020,
		S_AWR   = 16'h0040,
		S_NCAP  = 16'h0080,
		S_ZCHK  = 16'h0100,
		S_NORM  = 16'h0200,
		S_SQ    = 16'h0400,
		S_SQRT  = 16'h0800,
		S_DINIT = 16'h1000,
		S_DIV   = 16'h2000,
		S_DEND  = 16'h4000,
		S_FIN   = 16'h8000
	} state_t;

	state_t             state_q, state_d;
	logic [STEP_W-1:0]  cnt_q, cnt_d;
	logic [1:0]         comp_q, comp_d;
	status_t            st_q, st_d;
	logic               out_valid_q;

	assign out_valid = out_valid_q;

	// Next state and datapath command
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		comp_d = comp_q;
		st_d = st_q;
		in_ready = 1'b0;
		cmd.op = OP_IDLE;
		cmd.step = cnt_q;
		cmd.comp = comp_q;
		cmd.st = st_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				st_d = ST_OK;
				unique case (stat.code)
					CMD_LOAD: begin
						if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.op = OP_LOAD;
						end
						state_d = S_FIN;
					end
					CMD_TRI: begin
						if (stat.tri_bad) begin
							st_d = ST_SKIP;
							state_d = S_FIN;
						end else begin
							cnt_d = '0;
							state_d = S_PRD;
						end
					end
					CMD_READ: begin
						if (stat.rd_bad) begin
							st_d = ST_RDINV;
							state_d = S_FIN;
						end else begin
							cmd.op = OP_NRM_RD;
							state_d = S_NCAP;
						end
					end
					default: begin
						cmd.op = OP_CLEAR;
						state_d = S_FIN;
					end
				endcase
			end
			S_PRD: begin
				cmd.op = OP_POS_RD;
				cmd.comp = (cnt_q == PRD_LAST) ? 2'd0 : cnt_q[1:0];
				if (cnt_q == PRD_LAST) begin
					cnt_d = '0;
					state_d = S_DIFF;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_DIFF: begin
				cmd.op = OP_DIFF;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op = OP_MUL;
				if (cnt_q == MUL_LAST) begin
					cnt_d = '0;
					comp_d = '0;
					state_d = S_ARD;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_ARD: begin
				cmd.op = OP_ACC_RD;
				state_d = S_AWR;
			end
			S_AWR: begin
				cmd.op = OP_ACC_WR;
				if (comp_q == COMP_LAST) begin
					state_d = S_FIN;
				end else begin
					comp_d = comp_q + 2'd1;
					state_d = S_ARD;
				end
			end
			S_NCAP: begin
				cmd.op = OP_NRM_CAP;
				state_d = S_ZCHK;
			end
			S_ZCHK: begin
				if (stat.acc_zero) begin
					st_d = ST_ZERO;
					state_d = S_FIN;
				end else begin
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (stat.norm_ok) begin
					cnt_d = '0;
					state_d = S_SQ;
				end else begin
					cmd.op = OP_NORM;
				end
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				cmd.comp = cnt_q[1:0];
				if (cnt_q == SQ_LAST) begin
					cnt_d = '0;
					state_d = S_SQRT;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == SQRT_LAST) begin
					cnt_d = '0;
					comp_d = '0;
					state_d = S_DINIT;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_DINIT: begin
				cmd.op = OP_DIV_INIT;
				cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					state_d = S_DEND;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_DEND: begin
				cmd.op = OP_DIV_END;
				if (comp_q == COMP_LAST) begin
					state_d = S_FIN;
				end else begin
					comp_d = comp_q + 2'd1;
					state_d = S_DINIT;
				end
			end
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
			st_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			comp_q <= comp_d;
			st_q <= st_d;
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/vertex_normal_accumulator.sv */
// Top level of the vertex normal accumulator.
// Keeps up to MAX_VERTICES vertex positions (signed Q8.8) and one saturating
// ACCUM_BITS-wide normal accumulator per vertex. Command 0 appends a vertex,
// 1 adds a triangle's unnormalized cross product to its three corners, 2 reads
// one vertex's normal scaled to unit length in signed Q1.15, 3 empties the mesh.
// Every transaction gives exactly one response. One transaction is worked at a
// time by a controller that steps a datapath with single-port stores and a
// shared cross-product multiplier; a new request is taken while the previous
// response still waits in the output register. Load, clear and rejected
// commands go straight to the finish state; a triangle takes three position
// reads, six multiplies and three read-modify-writes of the accumulators; a
// read of a zero accumulator ends at the magnitude check; any other read
// shifts the magnitudes one bit per step until the largest has 31 bits, then
// takes 4 square steps, a 32-step square root and three 17-step restoring
// divisions. A finished response waits until the output register is free.
// Stores are not cleared after reset.
`default_nettype none
module vertex_normal_accumulator
	import vna_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = 1024,
	parameter int unsigned ACCUM_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	vna_req_if.sink  req,
	vna_rsp_if.source rsp
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	vna_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	vna_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.ACCUM_BITS   (ACCUM_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.command      (req.command),
		.read_index   (req.read_index),
		.pos_x        (req.pos_x),
		.pos_y        (req.pos_y),
		.pos_z        (req.pos_z),
		.index_a      (req.index_a),
		.index_b      (req.index_b),
		.index_c      (req.index_c),
		.status       (rsp.status),
		.normal_x     (rsp.normal_x),
		.normal_y     (rsp.normal_y),
		.normal_z     (rsp.normal_z)
	);

	// A vertex is never appended to a full store
	a_load_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == OP_LOAD |-> !dp_stat.full)
		else $error("vertex appended to full store");

	// Only one transaction in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while one is in flight");

	// Finishing always presents a response
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == OP_FINISH |=> rsp.valid)
		else $error("finished transaction has no response");

	// Division never runs on a zero-length normal
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == OP_DIV_INIT |-> !dp_stat.acc_zero)
		else $error("normalize of zero accumulator");

endmodule
`default_nettype wire

/* test/vertex_normal_accumulator_tb.sv */
// Self-checking testbench of the vertex normal accumulator: directed table, then random meshes.
module vertex_normal_accumulator_tb;
	import vna_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NVERT = 1024;
	localparam int unsigned ABITS = 48;
	localparam longint ACC_HI = (64'sd1 <<< (ABITS - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam int unsigned RAND_ITEMS = 720;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		cmd_code_t   command;
		logic [15:0] read_index;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [15:0] index_a;
		logic [15:0] index_b;
		logic [15:0] index_c;
	} vna_req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [15:0] normal_z;
	} vna_rsp_t;

	// One table row: request, optional typed-in response
	typedef struct {
		vna_req_t req;
		bit       fixed;
		vna_rsp_t rsp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	vna_req_if req_ch();
	vna_rsp_if rsp_ch();

	vertex_normal_accumulator #(.MAX_VERTICES(NVERT), .ACCUM_BITS(ABITS)) u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	// Mirror of the block state
	logic signed [15:0] mesh_pos [NVERT][3];
	longint mesh_acc [NVERT][3];
	int unsigned mesh_count;

	vna_rsp_t normal_queue[$];
	int unsigned error_count;
	int unsigned rsp_count;
	int unsigned sent_count;
	int unsigned read_ok_count, zero_count, skip_count, full_count;
	longint cycle_count;
	bit hold_rsp;
	dir_row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sat_sum(longint acc, longint d);
		if (d > 0 && acc > ACC_HI - d) begin
			return ACC_HI;
		end
		if (d < 0 && acc < ACC_LO - d) begin
			return ACC_LO;
		end
		return acc + d;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) begin
			bitv >>= 2;
		end
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Compute the expected response and update the mirror state
	function automatic vna_rsp_t mesh_apply(vna_req_t r);
		vna_rsp_t o;
		longint d1 [3];
		longint d2 [3];
		longint cr [3];
		longint unsigned m [3];
		longint unsigned mx, sum, len, q;
		int unsigned c [3];
		int sh, nb;
		o = '0;
		o.status = ST_OK;
		case (r.command)
			CMD_LOAD: begin
				if (mesh_count >= NVERT) begin
					o.status = ST_FULL;
				end else begin
					mesh_pos[mesh_count][0] = r.pos_x;
					mesh_pos[mesh_count][1] = r.pos_y;
					mesh_pos[mesh_count][2] = r.pos_z;
					for (int k = 0; k < 3; k++) mesh_acc[mesh_count][k] = 0;
					mesh_count++;
				end
			end
			CMD_TRI: begin
				c[0] = r.index_a;
				c[1] = r.index_b;
				c[2] = r.index_c;
				if (c[0] >= mesh_count || c[1] >= mesh_count || c[2] >= mesh_count) begin
					o.status = ST_SKIP;
				end else begin
					for (int k = 0; k < 3; k++) begin
						d1[k] = longint'(mesh_pos[c[1]][k]) - longint'(mesh_pos[c[0]][k]);
						d2[k] = longint'(mesh_pos[c[2]][k]) - longint'(mesh_pos[c[0]][k]);
					end
					cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
					cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
					cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
					for (int v = 0; v < 3; v++) begin
						for (int k = 0; k < 3; k++) begin
							mesh_acc[c[v]][k] = sat_sum(mesh_acc[c[v]][k], cr[k]);
						end
					end
				end
			end
			CMD_READ: begin
				if (r.read_index >= mesh_count) begin
					o.status = ST_RDINV;
				end else begin
					mx = 0;
					for (int k = 0; k < 3; k++) begin
						m[k] = mesh_acc[r.read_index][k] < 0 ?
							longint'(-mesh_acc[r.read_index][k]) :
							longint'(mesh_acc[r.read_index][k]);
						if (m[k] > mx) mx = m[k];
					end
					if (mx == 0) begin
						o.status = ST_ZERO;
					end else begin
						nb = 0;
						while ((mx >> nb) != 0) nb++;
						sh = nb - 31;
						sum = 0;
						for (int k = 0; k < 3; k++) begin
							if (sh > 0) m[k] >>= sh;
							else m[k] <<= -sh;
							sum += m[k] * m[k];
						end
						len = int_sqrt(sum);
						for (int k = 0; k < 3; k++) begin
							q = (m[k] * 32768 + (len >> 1)) / len;
							if (q > 32767) q = 32767;
							if (mesh_acc[r.read_index][k] < 0) q = (64'h10000 - q) & 64'hFFFF;
							case (k)
								0: o.normal_x = q[15:0];
								1: o.normal_y = q[15:0];
								default: o.normal_z = q[15:0];
							endcase
						end
					end
				end
			end
			default: begin
				mesh_count = 0;
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch at response %0d: %s got %h expected %h", rsp_count, what, got, want);
		error_count++;
	endtask

	function automatic vna_req_t mk_load(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		vna_req_t r;
		r = '0;
		r.command = CMD_LOAD;
		r.read_index = 16'($urandom);
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.index_a = 16'($urandom);
		return r;
	endfunction

	function automatic vna_req_t mk_tri(int unsigned a, int unsigned b, int unsigned c);
		vna_req_t r;
		r = '0;
		r.command = CMD_TRI;
		r.index_a = 16'(a);
		r.index_b = 16'(b);
		r.index_c = 16'(c);
		r.pos_x = 16'($urandom);
		return r;
	endfunction

	function automatic vna_req_t mk_read(int unsigned v);
		vna_req_t r;
		r = '0;
		r.command = CMD_READ;
		r.read_index = 16'(v);
		r.pos_y = 16'($urandom);
		return r;
	endfunction

	function automatic vna_req_t mk_clear();
		vna_req_t r;
		r = '0;
		r.command = CMD_CLEAR;
		r.index_c = 16'($urandom);
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request, predict it when accepted
	task automatic send_req(vna_req_t r, bit fixed, vna_rsp_t want);
		vna_rsp_t pred;
		int unsigned g;
		g = gap_len();
		// drop valid over an idle gap
		if (g != 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.command <= r.command;
		req_ch.read_index <= r.read_index;
		req_ch.pos_x <= r.pos_x;
		req_ch.pos_y <= r.pos_y;
		req_ch.pos_z <= r.pos_z;
		req_ch.index_a <= r.index_a;
		req_ch.index_b <= r.index_b;
		req_ch.index_c <= r.index_c;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pred = mesh_apply(r);
		if (fixed && pred != want) begin
			$display("table row %0d disagrees with prediction", sent_count);
			error_count++;
		end
		normal_queue.push_back(fixed ? want : pred);
		sent_count++;
	endtask

	// Receiver side: random ready, one long hold-off
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	// Check each response transaction against the oldest prediction
	always @(posedge clk) begin
		vna_rsp_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (normal_queue.size() == 0) begin
				$display("unexpected response status %0d", rsp_ch.status);
				error_count++;
			end else begin
				w = normal_queue.pop_front();
				if (rsp_ch.status !== w.status)
					report_mismatch("status", 16'(rsp_ch.status), 16'(w.status));
				if (rsp_ch.normal_x !== w.normal_x)
					report_mismatch("normal_x", rsp_ch.normal_x, w.normal_x);
				if (rsp_ch.normal_y !== w.normal_y)
					report_mismatch("normal_y", rsp_ch.normal_y, w.normal_y);
				if (rsp_ch.normal_z !== w.normal_z)
					report_mismatch("normal_z", rsp_ch.normal_z, w.normal_z);
				case (w.status)
					ST_OK: if (w.normal_x | w.normal_y | w.normal_z) read_ok_count++;
					ST_ZERO: zero_count++;
					ST_SKIP: skip_count++;
					ST_FULL: full_count++;
					default: ;
				endcase
			end
			rsp_count++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** vertex_normal_accumulator: FAILED **");
			$finish;
		end
	end

	// Long receiver stall in its own process
	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_rsp = 1'b1;
		repeat (400) @(posedge clk);
		hold_rsp = 1'b0;
	end

	task automatic build_table();
		dir_row_t row;
		vna_rsp_t z;
		z = '0;
		row.fixed = 1'b1;
		row.rsp = z;
		// read and triangle on an empty mesh
		row.rsp.status = ST_RDINV;
		row.req = mk_read(0);
		dir_rows.push_back(row);
		row.rsp.status = ST_SKIP;
		row.req = mk_tri(0, 0, 0);
		dir_rows.push_back(row);
		// position extremes
		row.rsp.status = ST_OK;
		row.req = mk_load(16'h0000, 16'h0000, 16'h0000);
		dir_rows.push_back(row);
		row.req = mk_load(16'h7FFF, 16'h0000, 16'h8000);
		dir_rows.push_back(row);
		row.req = mk_load(16'h8000, 16'h7FFF, 16'h7FFF);
		dir_rows.push_back(row);
		row.req = mk_load(16'h0100, 16'h0000, 16'h0000);
		dir_rows.push_back(row);
		// fresh vertex reads as zero length
		row.rsp.status = ST_ZERO;
		row.req = mk_read(0);
		dir_rows.push_back(row);
		// degenerate triangle changes nothing
		row.rsp.status = ST_OK;
		row.req = mk_tri(1, 1, 2);
		dir_rows.push_back(row);
		row.rsp.status = ST_ZERO;
		row.req = mk_read(1);
		dir_rows.push_back(row);
		// bad index and read out of range
		row.rsp.status = ST_SKIP;
		row.req = mk_tri(0, 1, 16'hFFFF);
		dir_rows.push_back(row);
		row.rsp.status = ST_RDINV;
		row.req = mk_read(16'hFFFF);
		dir_rows.push_back(row);
		row.req = mk_read(4);
		dir_rows.push_back(row);
		// predicted rows: extreme triangles, repeated, then reads of every vertex
		row.fixed = 1'b0;
		for (int i = 0; i < 6; i++) begin
			row.req = mk_tri(0, 1, 2);
			dir_rows.push_back(row);
		end
		row.req = mk_tri(3, 1, 2);
		dir_rows.push_back(row);
		for (int v = 0; v < 4; v++) begin
			row.req = mk_read(v);
			dir_rows.push_back(row);
		end
		row.fixed = 1'b1;
		row.rsp.status = ST_OK;
		row.req = mk_clear();
		dir_rows.push_back(row);
		row.rsp.status = ST_RDINV;
		row.req = mk_read(0);
		dir_rows.push_back(row);
	endtask

	function automatic logic [15:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned rand_vtx();
		if (mesh_count == 0 || $urandom_range(0, 19) == 0) return $urandom_range(0, 65535);
		return $urandom_range(0, mesh_count - 1);
	endfunction

	initial begin
		vna_req_t r;
		vna_rsp_t z;
		int unsigned n;
		int unsigned nload;
		z = '0;
		arst_n = 1'b0;
		hold_rsp = 1'b0;
		cycle_count = 0;
		error_count = 0;
		rsp_count = 0;
		sent_count = 0;
		mesh_count = 0;
		read_ok_count = 0;
		zero_count = 0;
		skip_count = 0;
		full_count = 0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.read_index = '0;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;
		req_ch.index_a = '0;
		req_ch.index_b = '0;
		req_ch.index_c = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		build_table();
		foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

		// Random meshes: load a few vertices, add triangles, read normals
		n = 0;
		while (n < RAND_ITEMS) begin
			nload = $urandom_range(3, 12);
			for (int i = 0; i < nload && n < RAND_ITEMS; i++) begin
				send_req(mk_load(rand_pos(), rand_pos(), rand_pos()), 1'b0, z);
				n++;
			end
			for (int i = 0; i < 25 && n < RAND_ITEMS; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: r = mk_tri(rand_vtx(), rand_vtx(), rand_vtx());
					5, 6, 7: r = mk_read(rand_vtx());
					8: r = mk_load(rand_pos(), rand_pos(), rand_pos());
					default: r = ($urandom_range(0, 3) == 0) ? mk_clear() : mk_read(rand_vtx());
				endcase
				send_req(r, 1'b0, z);
				n++;
			end
			if ($urandom_range(0, 2) == 0) begin
				send_req(mk_clear(), 1'b0, z);
				n++;
			end
		end
		req_ch.valid <= 1'b0;

		// Drain and settle
		while (normal_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests: %0d nonzero reads, %0d zero-length, %0d skipped, %0d full",
			sent_count, read_ok_count, zero_count, skip_count, full_count);
		if (error_count == 0) begin
			$display("** vertex_normal_accumulator: PASSED **");
		end else begin
			$display("%0d mismatches", error_count);
			$display("** vertex_normal_accumulator: FAILED **");
		end
		$finish;
	end

endmodule
